### hw/rtl/itp_pkg.sv
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int TAG_WIDTH   = 16;
    localparam int OP_W        = 6;
    localparam int PRIO_W      = 4;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic [OP_W-1:0] OP_LPAREN    = 6'd0;
    localparam logic [OP_W-1:0] OP_RPAREN    = 6'd1;
    localparam logic [OP_W-1:0] OP_MUL       = 6'd2;
    localparam logic [OP_W-1:0] OP_POW       = 6'd3;
    localparam logic [OP_W-1:0] OP_DIV       = 6'd4;
    localparam logic [OP_W-1:0] OP_MOD       = 6'd5;
    localparam logic [OP_W-1:0] OP_ADD       = 6'd6;
    localparam logic [OP_W-1:0] OP_SUB       = 6'd7;
    localparam logic [OP_W-1:0] OP_LT        = 6'd8;
    localparam logic [OP_W-1:0] OP_GT        = 6'd9;
    localparam logic [OP_W-1:0] OP_LE        = 6'd10;
    localparam logic [OP_W-1:0] OP_GE        = 6'd11;
    localparam logic [OP_W-1:0] OP_EQ        = 6'd12;
    localparam logic [OP_W-1:0] OP_IN        = 6'd13;
    localparam logic [OP_W-1:0] OP_NOT       = 6'd14;
    localparam logic [OP_W-1:0] OP_AND       = 6'd15;
    localparam logic [OP_W-1:0] OP_OR        = 6'd16;
    localparam logic [OP_W-1:0] OP_XOR       = 6'd17;
    localparam logic [OP_W-1:0] OP_LAST_CODE = 6'd36;

    localparam logic TOK_OPERAND = 1'b0;

    typedef enum logic [1:0] {
        KIND_OPERAND,
        KIND_OPERATOR,
        KIND_ERROR,
        KIND_END
    } out_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_STACK_FULL,
        ERR_BAD_CODE,
        ERR_RSVD
    } err_code_t;

    typedef struct packed {
        logic                 token_kind;
        logic [OP_W-1:0]      op_code;
        logic [TAG_WIDTH-1:0] operand_tag;
        logic                 end_of_expr;
    } token_t;

    typedef struct packed {
        logic [1:0]           out_kind;
        logic [OP_W-1:0]      out_op_code;
        logic [TAG_WIDTH-1:0] out_tag;
        logic [1:0]           error_code;
        logic                 last_of_run;
    } result_t;

    // in-stack priority
    function automatic logic [PRIO_W-1:0] isp_of(input logic [OP_W-1:0] code);
        logic [PRIO_W-1:0] p;
        case (code)
            OP_LPAREN:                          p = 4'd0;
            OP_RPAREN:                          p = 4'd15;
            OP_MUL, OP_POW, OP_DIV, OP_MOD:     p = 4'd12;
            OP_ADD, OP_SUB:                     p = 4'd10;
            OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ:  p = 4'd8;
            OP_IN:                              p = 4'd4;
            OP_NOT:                             p = 4'd3;
            OP_AND, OP_OR, OP_XOR:              p = 4'd2;
            default:                            p = 4'd14;
        endcase
        return p;
    endfunction

    // incoming priority
    function automatic logic [PRIO_W-1:0] icp_of(input logic [OP_W-1:0] code);
        logic [PRIO_W-1:0] p;
        case (code)
            OP_LPAREN:                          p = 4'd15;
            OP_RPAREN:                          p = 4'd0;
            OP_MUL, OP_POW, OP_DIV, OP_MOD:     p = 4'd11;
            OP_ADD, OP_SUB:                     p = 4'd9;
            OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ:  p = 4'd7;
            OP_IN:                              p = 4'd5;
            OP_NOT:                             p = 4'd6;
            OP_AND, OP_OR, OP_XOR:              p = 4'd1;
            default:                            p = 4'd13;
        endcase
        return p;
    endfunction

endpackage

### hw/rtl/itp_stack_ram.sv
module itp_stack_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 6,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-through on same-address read
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/infix_to_postfix_converter_top.sv
// an accepted item is registered, executed in S_EXEC, and each result is held in pend_reg before out_reg
// a new item is taken only in S_READY, once the last one's pops and its push or pair are done
// end flag: S_FLUSH pops each stacked entry in turn through the stack ram, then emits the end marker
// one pop per cycle while the output is not stalled is set by the registered stack ram read of the next top
// reset clears state, stack count and output valid; stack ram contents are not cleared
module infix_to_postfix_converter_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             token_valid,
    output logic             token_stall,
    input  itp_pkg::token_t  token,
    output logic             result_valid,
    input  logic             result_stall,
    output itp_pkg::result_t result
);

    typedef enum logic [1:0] {
        S_READY,
        S_EXEC,
        S_FLUSH
    } state_t;

    state_t                         state_reg, state_next;
    logic [itp_pkg::CNT_W-1:0]      cnt_reg, cnt_next, cnt_minus;
    itp_pkg::token_t                tok_reg, tok_next;
    itp_pkg::result_t               pend_reg, pend_next;
    logic                           pend_valid_reg, pend_valid_next;
    itp_pkg::result_t               out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;

    logic                           we;
    logic [itp_pkg::ADDR_W-1:0]     raddr;
    logic [itp_pkg::OP_W-1:0]       top_code;

    logic                           out_free;
    logic                           accept;
    logic                           emit, do_push, do_pop, op_done, flush_done, go;
    itp_pkg::result_t               emit_res;
    logic [itp_pkg::PRIO_W-1:0]     icp, isp;
    logic                           top_paren, stack_empty, stack_full;

    itp_stack_ram #(
        .DEPTH (itp_pkg::STACK_DEPTH),
        .WIDTH (itp_pkg::OP_W)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (cnt_reg[itp_pkg::ADDR_W-1:0]),
        .wdata (tok_reg.op_code),
        .raddr (raddr),
        .rdata (top_code)
    );

    assign cnt_minus    = cnt_next - itp_pkg::CNT_W'(1);
    assign raddr        = cnt_minus[itp_pkg::ADDR_W-1:0];

    assign out_free     = !out_valid_reg || !result_stall;
    assign token_stall  = !((state_reg == S_READY) && (!pend_valid_reg || out_free));
    assign accept       = token_valid && !token_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign icp          = itp_pkg::icp_of(tok_reg.op_code);
    assign isp          = itp_pkg::isp_of(top_code);
    assign top_paren    = (top_code == itp_pkg::OP_LPAREN) || (top_code == itp_pkg::OP_RPAREN);
    assign stack_empty  = (cnt_reg == '0);
    assign stack_full   = (cnt_reg >= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));

    always_comb
    begin
        emit       = 1'b0;
        emit_res   = '0;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        op_done    = 1'b0;
        flush_done = 1'b0;
        case (state_reg)
            S_EXEC:
            begin
                if (tok_reg.token_kind == itp_pkg::TOK_OPERAND)
                begin
                    emit              = 1'b1;
                    emit_res.out_kind = itp_pkg::KIND_OPERAND;
                    emit_res.out_tag  = tok_reg.operand_tag;
                    op_done           = 1'b1;
                end
                else if (tok_reg.op_code > itp_pkg::OP_LAST_CODE)
                begin
                    emit                = 1'b1;
                    emit_res.out_kind   = itp_pkg::KIND_ERROR;
                    emit_res.error_code = itp_pkg::ERR_BAD_CODE;
                    op_done             = 1'b1;
                end
                else if (stack_empty || (icp > isp))
                begin
                    if (stack_full)
                    begin
                        emit                = 1'b1;
                        emit_res.out_kind   = itp_pkg::KIND_ERROR;
                        emit_res.error_code = itp_pkg::ERR_STACK_FULL;
                    end
                    else
                    begin
                        do_push = 1'b1;
                    end
                    op_done = 1'b1;
                end
                else if (icp == isp)
                begin
                    do_pop  = 1'b1;
                    op_done = 1'b1;
                end
                else
                begin
                    do_pop               = 1'b1;
                    emit                 = !top_paren;
                    emit_res.out_kind    = itp_pkg::KIND_OPERATOR;
                    emit_res.out_op_code = top_code;
                end
            end
            S_FLUSH:
            begin
                if (stack_empty)
                begin
                    emit              = 1'b1;
                    emit_res.out_kind = itp_pkg::KIND_END;
                    flush_done        = 1'b1;
                end
                else
                begin
                    do_pop               = 1'b1;
                    emit                 = !top_paren;
                    emit_res.out_kind    = itp_pkg::KIND_OPERATOR;
                    emit_res.out_op_code = top_code;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // a held result moves out only when the next one is known
    assign go = !(emit && pend_valid_reg && !out_free);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        tok_next        = tok_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && result_stall;
        we              = 1'b0;
        case (state_reg)
            S_READY:
            begin
                if (pend_valid_reg && out_free)
                begin
                    out_next             = pend_reg;
                    out_next.last_of_run = 1'b1;
                    out_valid_next       = 1'b1;
                    pend_valid_next      = 1'b0;
                end
                if (accept)
                begin
                    tok_next   = token;
                    state_next = S_EXEC;
                end
            end
            S_EXEC, S_FLUSH:
            begin
                if (go)
                begin
                    if (do_push)
                    begin
                        we       = 1'b1;
                        cnt_next = cnt_reg + itp_pkg::CNT_W'(1);
                    end
                    if (do_pop)
                    begin
                        cnt_next = cnt_reg - itp_pkg::CNT_W'(1);
                    end
                    if (emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = emit_res;
                        pend_valid_next = 1'b1;
                    end
                    if (op_done)
                    begin
                        state_next = tok_reg.end_of_expr ? S_FLUSH : S_READY;
                    end
                    if (flush_done)
                    begin
                        state_next = S_READY;
                    end
                end
            end
            default:
            begin
                state_next = S_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_READY;
            cnt_reg        <= '0;
            tok_reg        <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            tok_reg        <= tok_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

    a_flush_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |=> (cnt_reg <= $past(cnt_reg)))
        else $error("stack grew during flush");

    a_push_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ((state_reg == S_EXEC) && !stack_full))
        else $error("push outside exec or on full stack");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.out_kind == itp_pkg::KIND_END)) |-> out_reg.last_of_run)
        else $error("end marker not last of run");

endmodule

### sim/postfix_order_checker.sv
`timescale 1ns / 100ps

module postfix_order_checker
    import itp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    token_valid,
    input  logic    token_stall,
    input  token_t  token,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      mismatches,
    output int      outstanding,
    output int      compared
);

    logic [OP_W-1:0] op_stack [STACK_DEPTH];
    int              stack_depth;
    result_t         item_results [$];
    result_t         pending_postfix [$];

    function automatic int unsigned stacked_rank(input logic [OP_W-1:0] c);
        int unsigned r;
        case (c)
            OP_LPAREN:                         r = 0;
            OP_RPAREN:                         r = 15;
            OP_MUL, OP_POW, OP_DIV, OP_MOD:    r = 12;
            OP_ADD, OP_SUB:                    r = 10;
            OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ: r = 8;
            OP_IN:                             r = 4;
            OP_NOT:                            r = 3;
            OP_AND, OP_OR, OP_XOR:             r = 2;
            default:                           r = 14;
        endcase
        return r;
    endfunction

    function automatic int unsigned arriving_rank(input logic [OP_W-1:0] c);
        int unsigned r;
        case (c)
            OP_LPAREN:                         r = 15;
            OP_RPAREN:                         r = 0;
            OP_MUL, OP_POW, OP_DIV, OP_MOD:    r = 11;
            OP_ADD, OP_SUB:                    r = 9;
            OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ: r = 7;
            OP_IN:                             r = 5;
            OP_NOT:                            r = 6;
            OP_AND, OP_OR, OP_XOR:             r = 1;
            default:                           r = 13;
        endcase
        return r;
    endfunction

    function automatic void add_result(input out_kind_t k, input logic [OP_W-1:0] c,
                                       input logic [TAG_WIDTH-1:0] tg, input err_code_t e);
        result_t r;
        r.out_kind    = k;
        r.out_op_code = c;
        r.out_tag     = tg;
        r.error_code  = e;
        r.last_of_run = 1'b0;
        item_results.insert(item_results.size(), r);
    endfunction

    // parentheses leave the stack silently
    function automatic void pop_top();
        logic [OP_W-1:0] top;
        stack_depth--;
        top = op_stack[ADDR_W'(stack_depth)];
        if (top != OP_LPAREN && top != OP_RPAREN)
            add_result(KIND_OPERATOR, top, '0, ERR_NONE);
    endfunction

    function automatic void reduce_operator(input logic [OP_W-1:0] code);
        bit          done;
        bit          paired;
        int unsigned inc;
        int unsigned stk;
        done   = 0;
        paired = 0;
        if (code > OP_LAST_CODE)
        begin
            add_result(KIND_ERROR, '0, '0, ERR_BAD_CODE);
        end
        else
        begin
            while (stack_depth > 0 && !done)
            begin
                inc = arriving_rank(code);
                stk = stacked_rank(op_stack[ADDR_W'(stack_depth - 1)]);
                if (inc > stk)
                begin
                    done = 1;
                end
                else if (inc == stk)
                begin
                    stack_depth--;
                    paired = 1;
                    done   = 1;
                end
                else
                begin
                    pop_top();
                end
            end
            if (!paired)
            begin
                if (stack_depth >= STACK_DEPTH)
                begin
                    add_result(KIND_ERROR, '0, '0, ERR_STACK_FULL);
                end
                else
                begin
                    op_stack[ADDR_W'(stack_depth)] = code;
                    stack_depth++;
                end
            end
        end
    endfunction

    function automatic void predict_postfix(input token_t t);
        result_t r;
        item_results.delete();
        if (t.token_kind == TOK_OPERAND)
            add_result(KIND_OPERAND, '0, t.operand_tag, ERR_NONE);
        else
            reduce_operator(t.op_code);
        if (t.end_of_expr)
        begin
            while (stack_depth > 0)
                pop_top();
            add_result(KIND_END, '0, '0, ERR_NONE);
        end
        if (item_results.size() > 0)
        begin
            r = item_results[item_results.size() - 1];
            r.last_of_run = 1'b1;
            item_results[item_results.size() - 1] = r;
        end
        foreach (item_results[i])
            pending_postfix.insert(pending_postfix.size(), item_results[i]);
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (pending_postfix.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got %h", $time, got);
        end
        else
        begin
            want = pending_postfix.pop_front();
            compared++;
            check_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
            check_field("out_op_code", 32'(want.out_op_code), 32'(got.out_op_code));
            check_field("out_tag", 32'(want.out_tag), 32'(got.out_tag));
            check_field("error_code", 32'(want.error_code), 32'(got.error_code));
            check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        end
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        compared    = 0;
        stack_depth = 0;
    end

    // a result can never stem from the item accepted at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_depth = 0;
            pending_postfix.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result);
            if (token_valid && !token_stall)
                predict_postfix(token);
        end
        outstanding = pending_postfix.size();
    end

endmodule

### sim/infix_to_postfix_converter_top_tb.sv
`timescale 1ns / 100ps

module infix_to_postfix_converter_top_tb;
    import itp_pkg::*;

    localparam logic TOK_OPERATOR = ~TOK_OPERAND;
    localparam logic [OP_W-1:0] OP_FIRST_FUNC = OP_XOR + 6'd1;
    localparam int RANDOM_TOKENS = 500;
    localparam int CYCLE_LIMIT   = 400000;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    token_valid  = 1'b0;
    logic    token_stall;
    token_t  token        = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int mismatches;
    int outstanding;
    int compared;

    token_t expr_tokens [$];
    int     tokens_sent = 0;
    int     expressions = 0;
    int     burst_left  = 0;
    int     cycles      = 0;
    int     stall_mode  = 0;
    int     mode_left   = 0;

    infix_to_postfix_converter_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token        (token),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    postfix_order_checker postfix_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token        (token),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .compared     (compared)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results still due", outstanding);
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall: free-running, stretches with no, light and heavy stall
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(10, 200);
        end
        mode_left--;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 9) < 3);
            default: result_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    function automatic token_t operand_tok(input logic [TAG_WIDTH-1:0] tg, input bit last);
        token_t t;
        t.token_kind  = TOK_OPERAND;
        t.op_code     = OP_W'($urandom_range(0, 63));
        t.operand_tag = tg;
        t.end_of_expr = last;
        return t;
    endfunction

    function automatic token_t operator_tok(input logic [OP_W-1:0] code, input bit last);
        token_t t;
        t.token_kind  = TOK_OPERATOR;
        t.op_code     = code;
        t.operand_tag = TAG_WIDTH'($urandom);
        t.end_of_expr = last;
        return t;
    endfunction

    function automatic token_t noise_tok();
        token_t t;
        t.token_kind  = 1'($urandom_range(0, 1));
        t.op_code     = OP_W'($urandom_range(0, 63));
        t.operand_tag = TAG_WIDTH'($urandom);
        t.end_of_expr = ($urandom_range(0, 4) == 0);
        return t;
    endfunction

    function automatic void queue_token(input token_t t);
        expr_tokens.insert(expr_tokens.size(), t);
    endfunction

    task automatic send_token(input token_t t);
        logic stalled;
        int   gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                token_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        token       <= t;
        token_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            stalled = token_stall;
            @(posedge clk);
        end
        while (stalled);
        tokens_sent++;
    endtask

    task automatic send_expression();
        while (expr_tokens.size() > 0)
            send_token(expr_tokens.pop_front());
        expressions++;
    endtask

    task automatic mark_end();
        token_t t;
        if (expr_tokens.size() > 0)
        begin
            t = expr_tokens[expr_tokens.size() - 1];
            t.end_of_expr = 1'b1;
            expr_tokens[expr_tokens.size() - 1] = t;
        end
    endtask

    task automatic build_expression(input int max_len);
        bit              need_operand;
        int              open;
        int              pick;
        logic [OP_W-1:0] code;
        need_operand = 1;
        open         = 0;
        forever
        begin
            if (need_operand)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15 && open < 6 && expr_tokens.size() < max_len)
                begin
                    queue_token(operator_tok(OP_LPAREN, 1'b0));
                    open++;
                end
                else if (pick < 25 && open < 6 && expr_tokens.size() < max_len)
                begin
                    code = OP_W'($urandom_range(OP_FIRST_FUNC, OP_LAST_CODE));
                    queue_token(operator_tok(code, 1'b0));
                    queue_token(operator_tok(OP_LPAREN, 1'b0));
                    open++;
                end
                else if (pick < 30 && expr_tokens.size() < max_len)
                begin
                    queue_token(operator_tok(OP_NOT, 1'b0));
                end
                else
                begin
                    queue_token(operand_tok(TAG_WIDTH'($urandom), 1'b0));
                    need_operand = 0;
                end
            end
            else if (open > 0 && ($urandom_range(0, 2) == 0
                                  || expr_tokens.size() >= max_len))
            begin
                queue_token(operator_tok(OP_RPAREN, 1'b0));
                open--;
            end
            else if (open == 0 && (expr_tokens.size() >= max_len
                                   || $urandom_range(0, 4) == 0))
            begin
                break;
            end
            else
            begin
                code = OP_W'($urandom_range(OP_MUL, OP_XOR));
                if (code == OP_NOT)
                    code = OP_AND;
                queue_token(operator_tok(code, 1'b0));
                need_operand = 1;
            end
        end
        mark_end();
    endtask

    task automatic build_deep_nest();
        int n;
        n = $urandom_range(28, 36);
        repeat (n)
        begin
            if ($urandom_range(0, 5) == 0)
                queue_token(operator_tok(OP_W'($urandom_range(OP_FIRST_FUNC, OP_LAST_CODE)),
                                         1'b0));
            else
                queue_token(operator_tok(OP_LPAREN, 1'b0));
        end
        if ($urandom_range(0, 1) == 0)
        begin
            queue_token(operand_tok(TAG_WIDTH'($urandom), 1'b0));
            repeat ($urandom_range(0, 6))
                queue_token(operator_tok(OP_RPAREN, 1'b0));
        end
        mark_end();
    endtask

    task automatic build_broken();
        int idx;
        build_expression($urandom_range(3, 15));
        idx = $urandom_range(0, expr_tokens.size() - 1);
        case ($urandom_range(0, 3))
            0:       expr_tokens.delete(idx);
            1:       expr_tokens.insert(idx, noise_tok());
            2:       expr_tokens.insert(idx, operator_tok(OP_RPAREN, 1'b0));
            default: while (expr_tokens.size() > idx + 1) void'(expr_tokens.pop_back());
        endcase
        mark_end();
    endtask

    initial
    begin
        int pick;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // precedence, nesting and a function call
        queue_token(operand_tok(16'hffff, 1'b0));
        queue_token(operator_tok(OP_ADD, 1'b0));
        queue_token(operand_tok(16'h0000, 1'b0));
        queue_token(operator_tok(OP_MUL, 1'b0));
        queue_token(operator_tok(OP_LPAREN, 1'b0));
        queue_token(operand_tok(16'h5a5a, 1'b0));
        queue_token(operator_tok(OP_POW, 1'b0));
        queue_token(operator_tok(OP_FIRST_FUNC, 1'b0));
        queue_token(operator_tok(OP_LPAREN, 1'b0));
        queue_token(operand_tok(16'ha5a5, 1'b0));
        queue_token(operator_tok(OP_RPAREN, 1'b0));
        queue_token(operator_tok(OP_RPAREN, 1'b1));
        send_expression();
        // unmatched close paren, then discarded by a pair and by a pop
        queue_token(operator_tok(OP_RPAREN, 1'b0));
        queue_token(operator_tok(OP_LPAREN, 1'b0));
        queue_token(operator_tok(OP_RPAREN, 1'b0));
        queue_token(operator_tok(OP_NOT, 1'b0));
        queue_token(operator_tok(OP_IN, 1'b0));
        queue_token(operand_tok(16'h0001, 1'b0));
        queue_token(operator_tok(OP_LAST_CODE + 6'd1, 1'b1));
        send_expression();
        // a bad code and the last valid code, a pushed-only end token
        queue_token(operator_tok(OP_LAST_CODE, 1'b0));
        queue_token(operator_tok(6'h3f, 1'b0));
        queue_token(operator_tok(OP_MOD, 1'b0));
        queue_token(operator_tok(OP_EQ, 1'b0));
        queue_token(operator_tok(OP_SUB, 1'b1));
        send_expression();

        build_deep_nest();
        send_expression();
        while (tokens_sent < RANDOM_TOKENS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                build_expression(($urandom_range(0, 7) == 0) ? $urandom_range(16, 40)
                                                             : $urandom_range(1, 15));
            else if (pick < 82)
                build_broken();
            else if (pick < 88)
                build_deep_nest();
            else
                repeat ($urandom_range(1, 6)) queue_token(noise_tok());
            send_expression();
        end
        token_valid <= 1'b0;

        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (60) @(posedge clk);
        @(negedge clk);

        $display("sent %0d tokens in %0d expressions incl. nesting overflow and bad codes",
                 tokens_sent, expressions);
        $display("compared %0d results against the predicted postfix order", compared);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
